// ===== hdl/spl_pkg.sv =====
// ----------------------------------------------------------------------------
// spl_pkg
// Constants and types shared by the slice particle linker.
// ----------------------------------------------------------------------------
package spl_pkg;
    localparam int SLICE_DEPTH = 1024;
    localparam int COORD_BITS  = 16;
    localparam int ID_BITS     = 16;
    localparam int MASS_BITS   = 24;
    localparam int CNT_BITS    = 8;
    localparam int ADDR_BITS   = $clog2(SLICE_DEPTH);
    localparam int LEN_BITS    = $clog2(SLICE_DEPTH + 1);
    localparam int MEM_ADDR_BITS = ADDR_BITS + 1;
    localparam int ENTRY_BITS  = 2 * COORD_BITS + MASS_BITS + ID_BITS + CNT_BITS;
    localparam int SQ_BITS     = 2 * COORD_BITS + 1;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_MIN    = 2'd1;
    localparam logic [1:0] REG_MAX    = 2'd2;
    localparam logic [1:0] REG_CHECK  = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [MASS_BITS-1:0]  mass;
        logic [ID_BITS-1:0]    id;
        logic [CNT_BITS-1:0]   cnt;
    } t_entry;
endpackage

// ===== hdl/spl_ram.sv =====
// ----------------------------------------------------------------------------
// spl_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module spl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/slice_particle_linker_core.sv =====
// ----------------------------------------------------------------------------
// slice_particle_linker_core
// Links 2D detections slice by slice into 3D particles.
// ----------------------------------------------------------------------------
// Usage: present a detection with i_start high while o_busy is low. The block
// scans every stored entry of the previous slice, one per cycle, from a single
// RAM holding both slice banks. The block takes no new detection until the scan
// over the RAM read port and the result are done and it is back in idle.
// The result appears for one cycle with o_valid high; the receiver cannot
// stall, so the block goes idle at once. Registers are written on the config
// channel (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data) while idle.
// After reset the slice lengths, bank select and id counter are zero and the
// registers hold their defaults; the RAM needs no clearing since only entries
// written in the current stack are read.
// ----------------------------------------------------------------------------
module slice_particle_linker_core
    import spl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_start_of_stack,
    input  logic                  i_start_of_slice,
    input  logic [COORD_BITS-1:0] i_x_pos,
    input  logic [COORD_BITS-1:0] i_y_pos,
    input  logic [MASS_BITS-1:0]  i_mass,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [23:0]           i_cfg_data,
    output logic                  o_valid,
    output logic [ID_BITS-1:0]    o_particle_id,
    output logic [CNT_BITS-1:0]   o_slice_count,
    output logic                  o_linked,
    output logic                  o_was_split,
    output logic                  o_store_full,
    output logic                  o_id_overflow
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    logic [23:0]          r_radius;
    logic [CNT_BITS-1:0]  r_min, r_max;
    logic                 r_check;
    logic [LEN_BITS-1:0]  r_prev_len, r_cur_len;
    logic                 r_bank;
    logic [ID_BITS:0]     r_next;
    logic [LEN_BITS-1:0]  r_idx;
    logic                 r_rd_vld;
    logic [COORD_BITS-1:0] r_x, r_y;
    logic [MASS_BITS-1:0] r_mass;
    logic                 r_hit;
    logic [ID_BITS-1:0]   r_hit_id;
    logic [CNT_BITS-1:0]  r_hit_cnt;
    logic [MASS_BITS-1:0] r_hit_mass;

    t_entry rd_entry, wr_entry;
    logic   we;
    logic [MEM_ADDR_BITS-1:0] waddr, raddr;

    spl_ram #(.WIDTH(ENTRY_BITS), .DEPTH(2 * SLICE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wr_entry),
        .i_raddr(raddr),
        .o_rdata(rd_entry)
    );

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 24'd1024;
            r_min    <= 8'd3;
            r_max    <= 8'd255;
            r_check  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_RADIUS: r_radius <= i_cfg_data;
                REG_MIN:    r_min    <= i_cfg_data[CNT_BITS-1:0];
                REG_MAX:    r_max    <= i_cfg_data[CNT_BITS-1:0];
                REG_CHECK:  r_check  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // distance of the entry read last cycle
    logic [COORD_BITS-1:0]   dx, dy;
    logic [2*COORD_BITS-1:0] dx2, dy2;
    logic [SQ_BITS-1:0]      r2;
    logic                    match;
    always_comb begin
        dx = (r_x >= rd_entry.x) ? r_x - rd_entry.x : rd_entry.x - r_x;
        dy = (r_y >= rd_entry.y) ? r_y - rd_entry.y : rd_entry.y - r_y;
        dx2 = (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dx);
        dy2 = (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(dy);
        r2 = SQ_BITS'(dx2) + SQ_BITS'(dy2);
        match = r_rd_vld && (r2 < SQ_BITS'(r_radius));
    end

    assign raddr = {~r_bank, r_idx[ADDR_BITS-1:0]};

    // final decision
    logic [CNT_BITS-1:0] inc_cnt;
    logic split, fresh, ovf;
    logic [ID_BITS-1:0] fresh_id, fin_id;
    logic [CNT_BITS-1:0] fin_cnt;
    always_comb begin
        inc_cnt  = (r_hit_cnt == '1) ? r_hit_cnt : r_hit_cnt + 1'b1;
        split    = r_hit && r_check &&
                   ((inc_cnt >= r_min && r_mass > r_hit_mass) || inc_cnt >= r_max);
        fresh    = !r_hit || split;
        ovf      = fresh && r_next[ID_BITS];
        fresh_id = r_next[ID_BITS] ? '1 : r_next[ID_BITS-1:0];
        fin_id   = fresh ? fresh_id : r_hit_id;
        fin_cnt  = fresh ? '0 : inc_cnt;
        wr_entry = '{x: r_x, y: r_y, mass: r_mass, id: fin_id, cnt: fin_cnt};
        we       = (r_state == S_DONE) && (r_cur_len < LEN_BITS'(SLICE_DEPTH));
        waddr    = {r_bank, r_cur_len[ADDR_BITS-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_prev_len <= '0;
            r_cur_len  <= '0;
            r_bank     <= 1'b0;
            r_next     <= '0;
            r_rd_vld   <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            o_valid  <= 1'b0;
            r_rd_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x <= i_x_pos;
                        r_y <= i_y_pos;
                        r_mass <= i_mass;
                        r_hit <= 1'b0;
                        r_idx <= '0;
                        r_state <= S_SCAN;
                        if (i_start_of_stack) begin
                            r_prev_len <= '0;
                            r_cur_len  <= '0;
                            r_next     <= '0;
                        end else if (i_start_of_slice) begin
                            r_bank     <= ~r_bank;
                            r_prev_len <= r_cur_len;
                            r_cur_len  <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    // issue one read a cycle; compare the one that came back
                    if (match) begin
                        r_hit      <= 1'b1;
                        r_hit_id   <= rd_entry.id;
                        r_hit_cnt  <= rd_entry.cnt;
                        r_hit_mass <= rd_entry.mass;
                    end
                    if (r_idx < r_prev_len) begin
                        r_rd_vld <= 1'b1;
                        r_idx    <= r_idx + 1'b1;
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (match) begin
                        r_hit      <= 1'b1;
                        r_hit_id   <= rd_entry.id;
                        r_hit_cnt  <= rd_entry.cnt;
                        r_hit_mass <= rd_entry.mass;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    o_valid       <= 1'b1;
                    o_particle_id <= fin_id;
                    o_slice_count <= fin_cnt;
                    o_linked      <= r_hit;
                    o_was_split   <= split;
                    o_store_full  <= !we;
                    o_id_overflow <= ovf;
                    if (fresh && !r_next[ID_BITS]) r_next <= r_next + 1'b1;
                    if (we) r_cur_len <= r_cur_len + 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
